@@ hdl/autlp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// autlp_pkg
// Shared types and constants of the terminal line parser: line geometry,
// cell layout, parse modes, character codes and controller/datapath buses.
// ----------------------------------------------------------------------------
package autlp_pkg;

  localparam int LINE_WIDTH = 64;
  localparam int COL_W      = $clog2(LINE_WIDTH + 1);
  localparam int ADDR_W     = $clog2(LINE_WIDTH);

  typedef struct packed {
    logic [15:0] code;
    logic [6:0]  fore;
    logic [6:0]  back;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  // parse modes
  localparam logic [2:0] MODE_TEXT = 3'd0;
  localparam logic [2:0] MODE_ESC  = 3'd1;
  localparam logic [2:0] MODE_CSI  = 3'd2;
  localparam logic [2:0] MODE_U3   = 3'd3;
  localparam logic [2:0] MODE_U4   = 3'd4;

  // received bytes of interest
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_SGR    = 8'h6d;
  localparam logic [7:0] CH_D0     = 8'h30;
  localparam logic [7:0] CH_D9     = 8'h39;

  // UTF-8 lead byte patterns
  localparam logic [7:0] LEAD3_MASK = 8'hf0;
  localparam logic [7:0] LEAD3_VAL  = 8'he0;
  localparam logic [7:0] LEAD2_MASK = 8'he0;
  localparam logic [7:0] LEAD2_VAL  = 8'hc0;

  // colours
  localparam logic [6:0] FORE_RESET = 7'd37;
  localparam logic [6:0] BACK_RESET = 7'd40;
  localparam logic [9:0] FG_LO  = 10'd30;
  localparam logic [9:0] FG_HI  = 10'd37;
  localparam logic [9:0] FGB_LO = 10'd90;
  localparam logic [9:0] FGB_HI = 10'd97;
  localparam logic [9:0] BG_LO  = 10'd40;
  localparam logic [9:0] BG_HI  = 10'd47;
  localparam logic [9:0] BGB_LO = 10'd100;
  localparam logic [9:0] BGB_HI = 10'd107;

  localparam logic [9:0] ACC_MAX = 10'd1023;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch the received byte
    logic pre;        // commit the mode-dependent front step
    logic plain;      // commit the plain-text step
    logic rd_plain;   // read the cell the plain step works on
    logic scan;       // line feed scan in progress
    logic scan_step;  // take the current cell into the run
    logic scan_end;   // close the run and clear the line
  } autlp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pre_consumed;
    logic pre_merge;
    logic is_bs;
    logic is_lf;
    logic cur_nz;
    logic pend_valid;
    logic out_free;
  } autlp_sts_t;

endpackage
`default_nettype wire

@@ hdl/autlp_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// autlp_in_if
// Byte input channel: valid/ready handshake with one received byte.
// ----------------------------------------------------------------------------
interface autlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ hdl/autlp_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// autlp_out_if
// Result channel: valid/ready handshake with one emitted line cell.
// ----------------------------------------------------------------------------
interface autlp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_point;
  logic [6:0]  fore_colour;
  logic [6:0]  back_colour;
  logic        empty_line;
  logic        last_cell;

  modport source (output valid, output code_point, output fore_colour,
                  output back_colour, output empty_line, output last_cell,
                  input ready);
  modport sink   (input valid, input code_point, input fore_colour,
                  input back_colour, input empty_line, input last_cell,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/ansi_utf8_terminal_line_parser.sv @@
`default_nettype none
// A byte is taken in the idle state, then the front step runs; a plain byte,
// control byte or escape byte ends there, while a backspace or a byte after a
// UTF-8 lead byte adds a store read and the plain step. A line feed then runs
// the scan, one cell per cycle while the output accepts, and closes the run;
// results go through an output register; a new byte waits until all is done.
// Reset (rst_n low, synchronous): valid bits, column, mode, accumulator clear.
// ----------------------------------------------------------------------------
// ansi_utf8_terminal_line_parser
// Serial terminal line parser: SGR colour escapes, UTF-8 decode, line store,
// and per-cell emission of each finished line.
// ----------------------------------------------------------------------------
module ansi_utf8_terminal_line_parser (
  input  wire logic  clk,
  input  wire logic  rst_n,
  autlp_in_if.sink   in_ch,
  autlp_out_if.source out_ch
);
  import autlp_pkg::*;

  autlp_cmd_t cmd;   // controller commands to the datapath
  autlp_sts_t sts;   // datapath status back to the controller
  logic       ctl_ready;

  // Controller: walks each transaction through front step, optional store
  // read and plain step; on line feed it runs the scan until the run closes.
  autlp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctl_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: parser registers, line store RAM with valid bits (a cell that
  // was never written since reset or the last line feed reads as zero), and
  // the result register that decouples the scan from the output side.
  // Colours come out of reset as 37 on 40; no clearing pass is needed.
  autlp_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .rx_byte     (in_ch.rx_byte),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .code_point  (out_ch.code_point),
    .fore_colour (out_ch.fore_colour),
    .back_colour (out_ch.back_colour),
    .empty_line  (out_ch.empty_line),
    .last_cell   (out_ch.last_cell)
  );

  assign in_ch.ready = ctl_ready;

endmodule
`default_nettype wire

@@ hdl/autlp_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// autlp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module autlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/autlp_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// autlp_datapath
// Parser registers, line store with per-cell valid bits, line feed scan and
// the result register.
// ----------------------------------------------------------------------------
module autlp_datapath (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire autlp_pkg::autlp_cmd_t  cmd,
  output autlp_pkg::autlp_sts_t       sts,
  input  wire logic [7:0]             rx_byte,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output logic [15:0]                 code_point,
  output logic [6:0]                  fore_colour,
  output logic [6:0]                  back_colour,
  output logic                        empty_line,
  output logic                        last_cell
);
  import autlp_pkg::*;

  logic [7:0]            byte_r;
  logic [2:0]            mode_r, mode_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [9:0]            acc_r, acc_nxt;
  logic [6:0]            fore_r, fore_nxt;
  logic [6:0]            back_r, back_nxt;
  logic [LINE_WIDTH-1:0] valid_r, valid_nxt;
  logic                  rd_valid_r;
  logic [COL_W-1:0]      idx_r, idx_nxt;
  cell_t                 pend_r, pend_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  cell_t                 out_cell_r, out_cell_nxt;
  logic                  out_empty_r, out_empty_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [CELL_W-1:0] ram_rdata;
  cell_t             rd_cell;
  logic [ADDR_W-1:0] raddr, waddr, plain_addr;
  logic              wr_en;
  cell_t             wr_cell;

  logic              col_lt, idx_lt, is_bs, is_lf, out_load, out_free;
  logic [13:0]       acc_mul;
  logic [9:0]        acc_sat;

  // front step
  logic              pre_consumed, pre_merge;
  logic [2:0]        mode_pre;
  logic [COL_W-1:0]  col_pre;
  logic [9:0]        acc_pre;
  logic [6:0]        fore_pre, back_pre;
  cell_t             merge_cell;

  // plain step
  logic [2:0]        mode_base, mode_pl;
  logic [COL_W-1:0]  col_pl;
  logic              pl_en;
  cell_t             pl_cell;

  assign rd_cell = rd_valid_r ? cell_t'(ram_rdata) : '0;
  assign col_lt  = (col_r < COL_W'(LINE_WIDTH));
  assign idx_lt  = (idx_r < COL_W'(LINE_WIDTH));
  assign is_bs   = (byte_r == CH_BS);
  assign is_lf   = (byte_r == CH_LF);

  assign acc_mul = (14'(acc_r) << 3) + (14'(acc_r) << 1) + 14'(byte_r[3:0]);
  assign acc_sat = (acc_mul > 14'(ACC_MAX)) ? ACC_MAX : acc_mul[9:0];

  always_comb begin
    pre_consumed = 1'b0;
    pre_merge    = 1'b0;
    mode_pre     = MODE_TEXT;
    col_pre      = col_r;
    acc_pre      = acc_r;
    fore_pre     = fore_r;
    back_pre     = back_r;
    merge_cell   = rd_cell;
    case (mode_r)
      MODE_ESC: begin
        if (byte_r == CH_LBRACK) begin
          pre_consumed = 1'b1;
          mode_pre     = MODE_CSI;
          acc_pre      = '0;
        end
      end
      MODE_CSI: begin
        pre_consumed = 1'b1;
        if (byte_r inside {[CH_D0:CH_D9]}) begin
          mode_pre = MODE_CSI;
          acc_pre  = acc_sat;
        end else if (byte_r == CH_SGR) begin
          if (acc_r inside {[FG_LO:FG_HI], [FGB_LO:FGB_HI]}) begin
            fore_pre = acc_r[6:0];
          end else if (acc_r inside {[BG_LO:BG_HI], [BGB_LO:BGB_HI]}) begin
            back_pre = acc_r[6:0];
          end
        end
      end
      MODE_U3: begin
        pre_merge       = 1'b1;
        merge_cell.code = rd_cell.code | {4'b0, byte_r[5:0], 6'b0};
        mode_pre        = MODE_U4;
      end
      MODE_U4: begin
        pre_merge       = 1'b1;
        merge_cell.code = rd_cell.code | {10'b0, byte_r[5:0]};
        merge_cell.fore = fore_r;
        merge_cell.back = back_r;
        col_pre         = col_lt ? col_r + COL_W'(1) : col_r;
      end
      default: ;
    endcase
  end

  assign mode_base  = cmd.pre ? mode_pre : mode_r;
  assign plain_addr = is_bs ? ADDR_W'(col_r - COL_W'(1)) : ADDR_W'(col_r);

  always_comb begin
    mode_pl = mode_base;
    col_pl  = col_r;
    pl_en   = 1'b0;
    pl_cell = rd_cell;
    if (byte_r == CH_ESC) begin
      mode_pl = MODE_ESC;
    end else if (byte_r == CH_CR || is_lf) begin
      col_pl = '0;
    end else if (is_bs) begin
      if (col_r != '0) begin
        col_pl       = col_r - COL_W'(1);
        pl_en        = 1'b1;
        pl_cell.code = '0;
      end
    end else if (byte_r[7]) begin
      if ((byte_r & LEAD3_MASK) == LEAD3_VAL) begin
        mode_pl      = MODE_U3;
        pl_en        = col_lt;
        pl_cell.code = {byte_r[3:0], 12'b0};
      end else if ((byte_r & LEAD2_MASK) == LEAD2_VAL) begin
        mode_pl      = MODE_U4;
        pl_en        = col_lt;
        pl_cell.code = {5'b0, byte_r[4:0], 6'b0};
      end
    end else begin
      pl_en   = col_lt;
      pl_cell = '{code: {8'b0, byte_r}, fore: fore_r, back: back_r};
      col_pl  = col_lt ? col_r + COL_W'(1) : col_r;
    end
  end

  // store write port
  always_comb begin
    wr_en   = 1'b0;
    wr_cell = pl_cell;
    waddr   = ADDR_W'(col_r);
    if (cmd.pre && pre_merge) begin
      wr_en   = col_lt;
      wr_cell = merge_cell;
    end else if (cmd.plain) begin
      wr_en   = pl_en;
      waddr   = plain_addr;
    end
  end

  // store read port
  always_comb begin
    if (cmd.plain && is_lf) begin
      raddr = '0;
    end else if (cmd.scan) begin
      raddr = cmd.scan_step ? ADDR_W'(idx_r + COL_W'(1)) : ADDR_W'(idx_r);
    end else if (cmd.rd_plain) begin
      raddr = plain_addr;
    end else begin
      raddr = ADDR_W'(col_r);
    end
  end

  autlp_ram #(
    .WIDTH (CELL_W),
    .DEPTH (LINE_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (wr_cell),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign out_load = (cmd.scan_step && pend_valid_r) || cmd.scan_end;

  always_comb begin
    mode_nxt       = mode_r;
    col_nxt        = col_r;
    acc_nxt        = acc_r;
    fore_nxt       = fore_r;
    back_nxt       = back_r;
    valid_nxt      = valid_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_cell_nxt   = out_cell_r;
    out_empty_nxt  = out_empty_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

    if (cmd.pre) begin
      mode_nxt = mode_pre;
      col_nxt  = col_pre;
      acc_nxt  = acc_pre;
      fore_nxt = fore_pre;
      back_nxt = back_pre;
    end
    if (cmd.plain) begin
      mode_nxt = mode_pl;
      col_nxt  = col_pl;
      if (is_lf) begin
        idx_nxt        = '0;
        pend_valid_nxt = 1'b0;
      end
    end
    if (wr_en) begin
      valid_nxt[waddr] = 1'b1;
    end

    if (cmd.scan_step) begin
      // the result register only takes a cell that is really pending
      if (pend_valid_r) begin
        out_cell_nxt  = pend_r;
        out_empty_nxt = 1'b0;
        out_last_nxt  = 1'b0;
      end
      pend_nxt       = rd_cell;
      pend_valid_nxt = 1'b1;
      idx_nxt        = idx_r + COL_W'(1);
    end
    if (cmd.scan_end) begin
      out_cell_nxt   = pend_valid_r ? pend_r : '0;
      out_empty_nxt  = !pend_valid_r;
      out_last_nxt   = pend_valid_r;
      pend_valid_nxt = 1'b0;
      valid_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_TEXT;
      col_r        <= '0;
      acc_r        <= '0;
      fore_r       <= FORE_RESET;
      back_r       <= BACK_RESET;
      valid_r      <= '0;
      rd_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      mode_r       <= mode_nxt;
      col_r        <= col_nxt;
      acc_r        <= acc_nxt;
      fore_r       <= fore_nxt;
      back_r       <= back_nxt;
      valid_r      <= valid_nxt;
      rd_valid_r   <= valid_r[raddr];
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= rx_byte;
    end
    pend_r      <= pend_nxt;
    out_cell_r  <= out_cell_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign sts = '{
    pre_consumed: pre_consumed,
    pre_merge:    pre_merge,
    is_bs:        is_bs,
    is_lf:        is_lf,
    cur_nz:       idx_lt && (rd_cell.code != '0),
    pend_valid:   pend_valid_r,
    out_free:     out_free
  };

  assign out_valid   = out_valid_r;
  assign code_point  = out_cell_r.code;
  assign fore_colour = out_cell_r.fore;
  assign back_colour = out_cell_r.back;
  assign empty_line  = out_empty_r;
  assign last_cell   = out_last_r;

endmodule
`default_nettype wire

@@ hdl/autlp_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// autlp_ctrl
// Sequencer: byte accept, front step, optional store read, plain step and
// line feed scan.
// ----------------------------------------------------------------------------
module autlp_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire autlp_pkg::autlp_sts_t sts,
  output autlp_pkg::autlp_cmd_t      cmd
);
  import autlp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_PLAIN,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.pre = 1'b1;
        if (sts.pre_consumed) begin
          state_nxt = S_IDLE;
        end else if (sts.pre_merge || sts.is_bs) begin
          state_nxt = S_RD;
        end else begin
          cmd.plain = 1'b1;
          state_nxt = sts.is_lf ? S_SCAN : S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd_plain = 1'b1;
        state_nxt    = S_PLAIN;
      end
      S_PLAIN: begin
        cmd.plain = 1'b1;
        state_nxt = sts.is_lf ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.cur_nz) begin
          cmd.scan_step = !sts.pend_valid || sts.out_free;
        end else if (sts.out_free) begin
          cmd.scan_end = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ dv/autlp_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// autlp_tb_pkg
// Line scoreboard for the terminal line parser: a cycle-free model of the
// parser state and a queue of the line cells it expects to see emitted.
// ----------------------------------------------------------------------------
package autlp_tb_pkg;
  import autlp_pkg::*;

  // one emitted result, in output channel field order
  typedef struct packed {
    logic [15:0] code;
    logic [6:0]  fore;
    logic [6:0]  back;
    logic        empty;
    logic        last;
  } line_result_t;

  class line_scoreboard;
    cell_t            row [LINE_WIDTH];
    logic [COL_W-1:0] col;
    logic [2:0]       mode;
    logic [9:0]       acc;
    logic [6:0]       fore;
    logic [6:0]       back;
    line_result_t     cells_due [$];
    int               errors;

    function new();
      foreach (row[i]) row[i] = '0;
      col    = '0;
      mode   = MODE_TEXT;
      acc    = '0;
      fore   = FORE_RESET;
      back   = BACK_RESET;
      errors = 0;
    endfunction

    function int pending();
      return cells_due.size();
    endfunction

    // writes past the right margin are dropped
    function void write_code(logic [15:0] v, bit merge);
      if (col < LINE_WIDTH) begin
        row[col].code = merge ? (row[col].code | v) : v;
      end
    endfunction

    function void tag_and_advance();
      if (col < LINE_WIDTH) begin
        row[col].fore = fore;
        row[col].back = back;
        col++;
      end
    endfunction

    // Update the parser model with one accepted byte; a line feed queues
    // the finished line's cells.
    function void absorb_byte(logic [7:0] c);
      int unsigned  acc_next;
      int           cnt;
      line_result_t r;

      case (mode)
        MODE_ESC: begin
          if (c == CH_LBRACK) begin
            mode = MODE_CSI;
            acc  = '0;
            return;
          end
          mode = MODE_TEXT;
        end
        MODE_CSI: begin
          if (c >= CH_D0 && c <= CH_D9) begin
            acc_next = acc * 10 + (c - CH_D0);
            acc      = (acc_next > ACC_MAX) ? ACC_MAX : acc_next[9:0];
            return;
          end
          if (c == CH_SGR) begin
            if ((acc >= FG_LO && acc <= FG_HI) || (acc >= FGB_LO && acc <= FGB_HI)) begin
              fore = acc[6:0];
            end else if ((acc >= BG_LO && acc <= BG_HI) ||
                         (acc >= BGB_LO && acc <= BGB_HI)) begin
              back = acc[6:0];
            end
          end
          mode = MODE_TEXT;
          return;
        end
        // continuation merge, then the byte is also taken as plain text
        MODE_U3: begin
          write_code({4'b0, c[5:0], 6'b0}, 1'b1);
          mode = MODE_U4;
        end
        MODE_U4: begin
          write_code({10'b0, c[5:0]}, 1'b1);
          tag_and_advance();
          mode = MODE_TEXT;
        end
        default: mode = MODE_TEXT;
      endcase

      if (c == CH_ESC) begin
        mode = MODE_ESC;
        return;
      end
      if (c == CH_CR) begin
        col = '0;
        return;
      end
      if (c == CH_LF) begin
        cnt = 0;
        while (cnt < LINE_WIDTH && row[cnt].code != 0) cnt++;
        if (cnt == 0) begin
          r         = '0;
          r.empty   = 1'b1;
          cells_due = {cells_due, r};
        end else begin
          for (int i = 0; i < cnt; i++) begin
            r.code    = row[i].code;
            r.fore    = row[i].fore;
            r.back    = row[i].back;
            r.empty   = 1'b0;
            r.last    = (i == cnt - 1);
            cells_due = {cells_due, r};
          end
        end
        foreach (row[i]) row[i] = '0;
        col = '0;
        return;
      end
      if (c == CH_BS) begin
        if (col > 0) begin
          col--;
          write_code(16'h0, 1'b0);
        end
        return;
      end
      if (c[7]) begin
        if ((c & LEAD3_MASK) == LEAD3_VAL) begin
          mode = MODE_U3;
          write_code({c[3:0], 12'b0}, 1'b0);
        end else if ((c & LEAD2_MASK) == LEAD2_VAL) begin
          mode = MODE_U4;
          write_code({5'b0, c[4:0], 6'b0}, 1'b0);
        end
        return;
      end
      write_code({8'b0, c}, 1'b0);
      tag_and_advance();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_cell(line_result_t got);
      line_result_t want;
      if (cells_due.size() == 0) begin
        report($sformatf("cell %h with no line pending", got.code));
        return;
      end
      want = cells_due.pop_front();
      if (got.code != want.code)
        report($sformatf("code_point %h, want %h", got.code, want.code));
      if (got.fore != want.fore)
        report($sformatf("fore_colour %0d, want %0d", got.fore, want.fore));
      if (got.back != want.back)
        report($sformatf("back_colour %0d, want %0d", got.back, want.back));
      if (got.empty != want.empty)
        report($sformatf("empty_line %b, want %b", got.empty, want.empty));
      if (got.last != want.last)
        report($sformatf("last_cell %b, want %b", got.last, want.last));
    endtask
  endclass

endpackage

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the terminal line parser. Feeds directed and
// random byte streams (colour escapes, UTF-8, controls, noise) with random
// gaps and output stalls, and checks every emitted cell against the
// scoreboard's model of the line store.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import autlp_pkg::*;
  import autlp_tb_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction at all
  localparam int RANDOM_ITEMS = 250;
  localparam int DRAIN_TAIL   = 100;   // longer than a full-line scan

  localparam logic [7:0] CH_ERASE = 8'h4a;  // 'J' final byte, ignored
  localparam logic [7:0] CH_ZERO  = 8'h30;  // leading zero in a number
  localparam logic [7:0] CONT_TAG = 8'h80;  // UTF-8 continuation prefix
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7e;

  logic clk = 1'b0;
  logic rst_n;
  bit   sender_steady;   // when set, the sender runs back to back
  int   bytes_sent;

  autlp_in_if  in_ch ();
  autlp_out_if out_ch ();

  line_scoreboard sb = new();

  ansi_utf8_terminal_line_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled on the rising edge. The output side is
  // checked before the input side is absorbed so a same-edge line feed can
  // never satisfy its own results.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    line_result_t seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen.code  = out_ch.code_point;
        seen.fore  = out_ch.fore_colour;
        seen.back  = out_ch.back_colour;
        seen.empty = out_ch.empty_line;
        seen.last  = out_ch.last_cell;
        sb.check_cell(seen);
      end
      if (in_ch.valid && in_ch.ready) sb.absorb_byte(in_ch.rx_byte);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any transaction on either channel restarts the count.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side back-pressure: bursts of ready, mostly short, sometimes a
  // long open stretch, separated by random stalls.
  // --------------------------------------------------------------------------
  initial begin : sink_ready
    int burst;
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      repeat (burst) @(negedge clk) out_ch.ready <= 1'b1;
      gap = pick_gap();
      repeat (gap) @(negedge clk) out_ch.ready <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Valid is left high after a transaction; the next call either
  // lowers it for a gap or replaces the byte, always at a falling edge.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // Pause the sender until every queued cell has come out.
  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // ESC [ number final. Numbers favor the colour ranges but also cover
  // junk, saturation and the empty parameter.
  task automatic send_sgr();
    int    sel;
    int    value;
    int    r;
    string txt;
    sel = $urandom_range(0, 4);
    case (sel)
      0:       value = ($urandom_range(0, 1) ? 90 : 30) + $urandom_range(0, 7);
      1:       value = ($urandom_range(0, 1) ? 100 : 40) + $urandom_range(0, 7);
      2:       value = $urandom_range(0, 999);
      3:       value = $urandom_range(1000, 99999);
      default: value = -1;
    endcase
    send_byte(CH_ESC);
    send_byte(CH_LBRACK);
    if (value >= 0) begin
      if ($urandom_range(0, 7) == 0) send_byte(CH_ZERO);
      txt = $sformatf("%0d", value);
      for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
    end
    r = $urandom_range(0, 9);
    if (r < 8)       send_byte(CH_SGR);
    else if (r == 8) send_byte(CH_ERASE);
    else             send_byte(8'($urandom_range(0, 255)));
  endtask

  // One random line closed by a line feed. An overlong line runs past the
  // right margin so the dropped-write path and a full 64-cell run are hit.
  task automatic send_random_line(input bit overlong);
    int ntok;
    int kind;
    if (overlong) begin
      repeat ($urandom_range(66, 80)) send_byte(8'($urandom_range(PRINT_LO, PRINT_HI)));
      if ($urandom_range(0, 1)) send_byte(CH_BS);
    end else begin
      ntok = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 8);
      repeat (ntok) begin
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(PRINT_LO, PRINT_HI)));
        end else if (kind < 55) begin
          send_sgr();
        end else if (kind < 65) begin
          send_byte(LEAD2_VAL | 8'($urandom_range(0, 31)));
          send_byte(CONT_TAG | 8'($urandom_range(0, 63)));
        end else if (kind < 75) begin
          send_byte(LEAD3_VAL | 8'($urandom_range(0, 15)));
          send_byte(CONT_TAG | 8'($urandom_range(0, 63)));
          send_byte(CONT_TAG | 8'($urandom_range(0, 63)));
        end else if (kind < 80) begin
          // broken UTF-8: lead byte followed by anything
          send_byte($urandom_range(0, 1) ? (LEAD2_VAL | 8'($urandom_range(0, 31)))
                                         : (LEAD3_VAL | 8'($urandom_range(0, 15))));
          send_byte(8'($urandom_range(0, 255)));
        end else if (kind < 85) begin
          send_byte(CH_CR);
        end else if (kind < 90) begin
          send_byte(CH_BS);
        end else if (kind < 95) begin
          send_byte(CH_ESC);
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_byte(8'($urandom_range(0, 255)));
        end
      end
    end
    send_byte(CH_LF);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] directed [$];
    int         base;
    int         line_no;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    sender_steady = 1'b0;
    bytes_sent    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty line, backspace at the margin, fore and bright back
    // colour select, 2- and 3-byte UTF-8, an unsupported lead byte, ESC not
    // followed by '[', backspace mid-line, carriage return overwrite, then a
    // zero byte at column 0 giving an empty line.
    directed = {CH_LF, CH_BS, 8'h41,
                CH_ESC, CH_LBRACK, 8'h33, 8'h31, CH_SGR,
                8'h42,
                CH_ESC, CH_LBRACK, 8'h31, 8'h30, 8'h37, CH_SGR,
                8'hc3, 8'ha9,
                8'he2, 8'h82, 8'hac,
                8'hff,
                CH_ESC, 8'h78,
                8'h44, CH_BS,
                CH_CR, 8'h43, CH_LF,
                8'h00, CH_LF};
    foreach (directed[i]) send_byte(directed[i]);

    // let everything come out before the random part starts
    hold_until_drained();

    base    = bytes_sent;
    line_no = 0;
    while (bytes_sent - base < RANDOM_ITEMS) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) hold_until_drained();
      send_random_line(line_no == 2 || $urandom_range(0, 24) == 0);
      line_no++;
    end

    hold_until_drained();
    repeat (DRAIN_TAIL) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
